>>> sv/tccw_pkg.sv
package tccw_pkg;

    // Grid size defaults
    localparam int TCCW_MAX_COLS = 128;
    localparam int TCCW_MAX_ROWS = 64;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_TAB_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS_IN_USE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE = 2'd2;

    localparam logic [3:0] TAB_WIDTH_RESET   = 4'd4;
    localparam logic [7:0] COLS_IN_USE_RESET = 8'd80;
    localparam logic [6:0] ROWS_IN_USE_RESET = 7'd25;
    localparam logic [3:0] TAB_WIDTH_MAX     = 4'd8;

    // Character codes
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;

    // Result kinds
    localparam logic EV_CELL = 1'b0;
    localparam logic EV_LINE = 1'b1;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PRE   = 4'b0010,
        S_MERGE = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

endpackage

>>> sv/tccw_ram.sv
module tccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> sv/text_console_cell_writer.sv
// Printable code: the item passes S_PRE, S_MERGE and S_EMIT before its result is registered.
// Tab: a space cell per tab position (grid line read, then write-back), tab_eff cells per item.
// Newline: goes from S_IDLE straight to S_EMIT, with no grid line access.
// One item in work at a time; a stalled output holds the block in place.
// Reset: cursor and top offset go to zero, every grid line is marked empty by a
// per-line valid bit (no clearing pass); a scroll clears the valid bit of the new bottom line.
module text_console_cell_writer
    import tccw_pkg::*;
#(
    parameter int MAX_COLS = TCCW_MAX_COLS,
    parameter int MAX_ROWS = TCCW_MAX_ROWS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [7:0] char_code
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [6:0] cell_col, [12:7] cell_row,
                                              // [20:13] cell_char, [21] scrolled,
                                              // [27:22] top_line, [31:28] zero
    output logic [0:0]             m_tuser,   // [0] event_kind
    output logic                   m_tlast,   // last_result
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW     = $clog2(MAX_COLS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int LINE_W = MAX_COLS * 8;

    typedef struct packed {
        logic [RW-1:0] row;
        logic [RW-1:0] top;
        logic [RW-1:0] bottom;
        logic          sc;
    } adv_t;

    // (a + b) mod MAX_ROWS, with a < MAX_ROWS and b <= MAX_ROWS
    function automatic logic [RW-1:0] mod_add(input logic [RW-1:0] a, input logic [RW:0] b);
        logic [RW+1:0] s;
        s = {2'b00, a} + {1'b0, b};
        if (s >= (RW+2)'(MAX_ROWS))
        begin
            s = s - (RW+2)'(MAX_ROWS);
        end
        return s[RW-1:0];
    endfunction

    function automatic adv_t line_adv(input logic [RW-1:0] row, input logic [RW-1:0] top,
                                      input logic [RW:0] rows);
        adv_t          r;
        logic [RW:0]   row_p1;
        logic [RW:0]   rows_m1;
        row_p1  = {1'b0, row} + 1'b1;
        rows_m1 = rows - 1'b1;
        r.top    = top;
        r.bottom = top;
        r.row    = row_p1[RW-1:0];
        r.sc     = 1'b0;
        if (row_p1 >= rows)
        begin
            r.top    = mod_add(top, (RW+1)'(1));
            r.bottom = mod_add(r.top, rows_m1);
            r.row    = rows_m1[RW-1:0];
            r.sc     = 1'b1;
        end
        return r;
    endfunction

    // configuration
    logic [3:0] tab_width_reg;
    logic [7:0] cols_in_use_reg;
    logic [6:0] rows_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg   <= TAB_WIDTH_RESET;
            cols_in_use_reg <= COLS_IN_USE_RESET;
            rows_in_use_reg <= ROWS_IN_USE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TAB_WIDTH:   tab_width_reg   <= cfg_data[3:0];
                REG_COLS_IN_USE: cols_in_use_reg <= cfg_data[7:0];
                REG_ROWS_IN_USE: rows_in_use_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic [CW:0] cols_eff;
    logic [RW:0] rows_eff;
    logic [RW:0] rows_m1;
    logic [3:0]  tab_eff;
    logic [8:0]  cols9;
    logic [8:0]  rows9;

    always_comb
    begin
        cols9 = {1'b0, cols_in_use_reg};
        rows9 = {2'b00, rows_in_use_reg};
        if (cols9 == 9'd0)
            cols_eff = (CW+1)'(1);
        else if (cols9 > 9'(MAX_COLS))
            cols_eff = (CW+1)'(MAX_COLS);
        else
            cols_eff = (CW+1)'(cols9);
        if (rows9 == 9'd0)
            rows_eff = (RW+1)'(1);
        else if (rows9 > 9'(MAX_ROWS))
            rows_eff = (RW+1)'(MAX_ROWS);
        else
            rows_eff = (RW+1)'(rows9);
        if (tab_width_reg == 4'd0)
            tab_eff = 4'd1;
        else if (tab_width_reg > TAB_WIDTH_MAX)
            tab_eff = TAB_WIDTH_MAX;
        else
            tab_eff = tab_width_reg;
        rows_m1 = rows_eff - 1'b1;
    end

    // sequencer state
    state_t              state_reg, state_next;
    logic [CW-1:0]       cur_col_reg, cur_col_next;
    logic [RW-1:0]       cur_row_reg, cur_row_next;
    logic [RW-1:0]       top_reg, top_next;
    logic [7:0]          ch_reg, ch_next;
    logic [3:0]          left_reg, left_next;
    logic                sc_reg, sc_next;
    logic [RW-1:0]       line_reg, line_next;
    logic [MAX_ROWS-1:0] line_valid_reg, line_valid_next;

    logic                pend_kind_reg, pend_kind_next;
    logic [CW-1:0]       pend_col_reg, pend_col_next;
    logic [RW-1:0]       pend_row_reg, pend_row_next;
    logic [7:0]          pend_char_reg, pend_char_next;
    logic                pend_sc_reg, pend_sc_next;
    logic [RW-1:0]       pend_top_reg, pend_top_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_kind_reg;
    logic [CW-1:0]       m_col_reg;
    logic [RW-1:0]       m_row_reg;
    logic [7:0]          m_char_reg;
    logic                m_sc_reg;
    logic [RW-1:0]       m_top_reg;
    logic                m_last_reg;

    logic                ram_we;
    logic [RW-1:0]       ram_addr;
    logic [LINE_W-1:0]   ram_wdata;
    logic [LINE_W-1:0]   ram_rdata;

    tccw_ram #(
        .WIDTH(LINE_W),
        .DEPTH(MAX_ROWS)
    ) u_grid (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    logic          in_xfer;
    logic          load_out;
    logic [RW-1:0] row_cl;
    logic [CW:0]   col_p1;
    adv_t          adv_nl;
    adv_t          adv_pre;
    adv_t          adv_post;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign load_out = (state_reg == S_EMIT) && (!m_valid_reg || m_tready);

    always_comb
    begin
        row_cl   = ({1'b0, cur_row_reg} >= rows_eff) ? rows_m1[RW-1:0] : cur_row_reg;
        col_p1   = {1'b0, cur_col_reg} + 1'b1;
        adv_nl   = line_adv(row_cl, top_reg, rows_eff);
        adv_pre  = line_adv(cur_row_reg, top_reg, rows_eff);
        adv_post = line_adv(cur_row_reg, top_reg, rows_eff);
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        top_next        = top_reg;
        ch_next         = ch_reg;
        left_next       = left_reg;
        sc_next         = sc_reg;
        line_next       = line_reg;
        line_valid_next = line_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_col_next   = pend_col_reg;
        pend_row_next   = pend_row_reg;
        pend_char_next  = pend_char_reg;
        pend_sc_next    = pend_sc_reg;
        pend_top_next   = pend_top_reg;
        ram_we          = 1'b0;
        ram_addr        = line_reg;
        ram_wdata       = line_valid_reg[line_reg] ? ram_rdata : '0;
        ram_wdata[cur_col_reg*8 +: 8] = ch_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cur_row_next = row_cl;
                    if (s_tdata == CHAR_NEWLINE)
                    begin
                        cur_col_next   = '0;
                        cur_row_next   = adv_nl.row;
                        top_next       = adv_nl.top;
                        if (adv_nl.sc)
                            line_valid_next[adv_nl.bottom] = 1'b0;
                        pend_kind_next = EV_LINE;
                        pend_col_next  = '0;
                        pend_row_next  = '0;
                        pend_char_next = '0;
                        pend_sc_next   = adv_nl.sc;
                        pend_top_next  = adv_nl.top;
                        left_next      = 4'd1;
                        state_next     = S_EMIT;
                    end
                    else if (s_tdata == CHAR_TAB)
                    begin
                        ch_next    = CHAR_SPACE;
                        left_next  = tab_eff;
                        state_next = S_PRE;
                    end
                    else
                    begin
                        ch_next    = s_tdata;
                        left_next  = 4'd1;
                        state_next = S_PRE;
                    end
                end
            end

            S_PRE:
            begin
                // cursor left past the columns in use: wrap before the write
                sc_next = 1'b0;
                if ({1'b0, cur_col_reg} >= cols_eff)
                begin
                    cur_col_next = '0;
                    cur_row_next = adv_pre.row;
                    top_next     = adv_pre.top;
                    sc_next      = adv_pre.sc;
                    if (adv_pre.sc)
                        line_valid_next[adv_pre.bottom] = 1'b0;
                    line_next    = mod_add(adv_pre.top, {1'b0, adv_pre.row});
                end
                else
                begin
                    line_next = mod_add(top_reg, {1'b0, cur_row_reg});
                end
                ram_addr   = line_next;
                state_next = S_MERGE;
            end

            S_MERGE:
            begin
                ram_we                    = 1'b1;
                line_valid_next[line_reg] = 1'b1;
                pend_kind_next = EV_CELL;
                pend_col_next  = cur_col_reg;
                pend_row_next  = cur_row_reg;
                pend_char_next = ch_reg;
                pend_sc_next   = sc_reg;
                pend_top_next  = top_reg;
                cur_col_next   = col_p1[CW-1:0];
                if (col_p1 >= cols_eff)
                begin
                    cur_col_next = '0;
                    cur_row_next = adv_post.row;
                    top_next     = adv_post.top;
                    pend_top_next = adv_post.top;
                    if (adv_post.sc)
                    begin
                        pend_sc_next = 1'b1;
                        line_valid_next[adv_post.bottom] = 1'b0;
                    end
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (load_out)
                begin
                    if (left_reg == 4'd1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        left_next  = left_reg - 1'b1;
                        state_next = S_PRE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            top_reg        <= '0;
            left_reg       <= '0;
            sc_reg         <= 1'b0;
            line_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            top_reg        <= top_next;
            left_reg       <= left_next;
            sc_reg         <= sc_next;
            line_valid_reg <= line_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        line_reg      <= line_next;
        pend_kind_reg <= pend_kind_next;
        pend_col_reg  <= pend_col_next;
        pend_row_reg  <= pend_row_next;
        pend_char_reg <= pend_char_next;
        pend_sc_reg   <= pend_sc_next;
        pend_top_reg  <= pend_top_next;
        if (load_out)
        begin
            m_kind_reg <= pend_kind_reg;
            m_col_reg  <= pend_col_reg;
            m_row_reg  <= pend_row_reg;
            m_char_reg <= pend_char_reg;
            m_sc_reg   <= pend_sc_reg;
            m_top_reg  <= pend_top_reg;
            m_last_reg <= (left_reg == 4'd1);
        end
    end

    always_comb
    begin
        if (load_out)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    // output packing
    logic [15:0] col16;
    logic [15:0] row16;
    logic [15:0] top16;

    assign col16    = 16'(m_col_reg);
    assign row16    = 16'(m_row_reg);
    assign top16    = 16'(m_top_reg);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, top16[5:0], m_sc_reg, m_char_reg, row16[5:0], col16[6:0]};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    // a cell write never lands past the columns in use
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> ({1'b0, cur_col_reg} < cols_eff))
        else $error("cell write column beyond columns in use");

    // the line just written back stays marked as holding data
    a_line_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |=> line_valid_reg[$past(line_reg)])
        else $error("written grid line not marked valid");

    // ring offset stays inside the grid
    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, top_reg} < (RW+1)'(MAX_ROWS))
        else $error("top offset out of range");

    // no new input while an item is still in work
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_tready)
        else $error("input taken while busy");
`endif

endmodule
